// File: design/das_pkg.sv
package das_pkg;

	localparam int SEGMENT_SPLIT  = 4;
	localparam int RETUNE_LATERAL = 31;
	localparam int RETUNE_RANGE   = 614;
	localparam int SEG_SQ         = SEGMENT_SPLIT * SEGMENT_SPLIT;
	localparam int SEG_SQ_W       = $clog2(SEG_SQ + 1);

	localparam int XW     = 16;
	localparam int YAWW   = 15;
	localparam int ODW    = 20;
	localparam int CMDW   = 13;
	localparam int SPDW   = 12;
	localparam int DISTW  = 15;
	localparam int BANDW  = 14;
	localparam int PHW    = 3;
	localparam int CIDXW  = 3;
	localparam int CDW    = 15;
	localparam int ANGW   = 17;
	localparam int SQXW   = 2 * XW - 1;

	localparam int YAW_TOL     = 41;
	localparam int YAW_TARGET2 = 6431;
	localparam int YAW_LIMIT   = 12861;

	localparam logic [SPDW-1:0]  RST_SLOW_LIN  = SPDW'(102);
	localparam logic [SPDW-1:0]  RST_FAST_LIN  = SPDW'(307);
	localparam logic [SPDW-1:0]  RST_SLOW_TURN = SPDW'(102);
	localparam logic [SPDW-1:0]  RST_FAST_TURN = SPDW'(307);
	localparam logic [DISTW-1:0] RST_STOP_DIST = DISTW'(307);
	localparam logic [DISTW-1:0] RST_CTR_TOL   = DISTW'(31);
	localparam logic [DISTW-1:0] RST_SLOW_ZONE = DISTW'(307);
	localparam logic [BANDW-1:0] RST_TURN_BAND = BANDW'(1638);

	localparam logic [PHW-1:0] PCODE_TURN1    = 3'd0;
	localparam logic [PHW-1:0] PCODE_DRIVE    = 3'd1;
	localparam logic [PHW-1:0] PCODE_TURN2    = 3'd2;
	localparam logic [PHW-1:0] PCODE_APPROACH = 3'd3;
	localparam logic [PHW-1:0] PCODE_STOP     = 3'd4;
	localparam logic [PHW-1:0] PCODE_DONE     = 3'd5;

	typedef enum logic [5:0] {
		PH_TURN1    = 6'b000001,
		PH_DRIVE    = 6'b000010,
		PH_TURN2    = 6'b000100,
		PH_APPROACH = 6'b001000,
		PH_STOP     = 6'b010000,
		PH_DONE     = 6'b100000
	} phase_t;

	typedef enum logic [CIDXW-1:0] {
		CFG_SLOW_LIN  = 3'd0,
		CFG_FAST_LIN  = 3'd1,
		CFG_SLOW_TURN = 3'd2,
		CFG_FAST_TURN = 3'd3,
		CFG_STOP_DIST = 3'd4,
		CFG_CTR_TOL   = 3'd5,
		CFG_SLOW_ZONE = 3'd6,
		CFG_TURN_BAND = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [SPDW-1:0]  slow_rate;
		logic [SPDW-1:0]  fast_rate;
		logic [BANDW-1:0] band;
	} turn_cfg_t;

	typedef struct packed {
		logic                   done;
		logic signed [CMDW-1:0] angular;
	} turn_res_t;

	function automatic logic [PHW-1:0] phase_code(phase_t p);
		logic [PHW-1:0] c;
		case (p)
			PH_TURN1:    c = PCODE_TURN1;
			PH_DRIVE:    c = PCODE_DRIVE;
			PH_TURN2:    c = PCODE_TURN2;
			PH_APPROACH: c = PCODE_APPROACH;
			PH_STOP:     c = PCODE_STOP;
			PH_DONE:     c = PCODE_DONE;
			default:     c = PCODE_TURN1;
		endcase
		return c;
	endfunction

endpackage

// File: design/das_pose_if.sv
interface das_pose_if;
	logic                            valid;
	logic                            ready;
	logic signed [das_pkg::XW-1:0]   dock_x;
	logic signed [das_pkg::XW-1:0]   dock_y;
	logic signed [das_pkg::YAWW-1:0] dock_heading;
	logic signed [das_pkg::ODW-1:0]  odom_x;
	logic signed [das_pkg::ODW-1:0]  odom_y;

	modport source (output valid, dock_x, dock_y, dock_heading, odom_x, odom_y, input ready);
	modport sink (input valid, dock_x, dock_y, dock_heading, odom_x, odom_y, output ready);
endinterface

// File: design/das_cmd_if.sv
interface das_cmd_if;
	logic                            valid;
	logic                            ready;
	logic signed [das_pkg::CMDW-1:0] linear_command;
	logic signed [das_pkg::CMDW-1:0] angular_command;
	logic [das_pkg::PHW-1:0]         phase;
	logic                            finished;

	modport source (output valid, linear_command, angular_command, phase, finished,
		input ready);
	modport sink (input valid, linear_command, angular_command, phase, finished,
		output ready);
endinterface

// File: design/das_cfg_if.sv
interface das_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [das_pkg::CIDXW-1:0]  index;
	logic [das_pkg::CDW-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: design/das_turn.sv
module das_turn (
	input  logic signed [das_pkg::YAWW-1:0] yaw,
	input  logic signed [das_pkg::ANGW-1:0] target,
	input  das_pkg::turn_cfg_t              tcfg,
	output das_pkg::turn_res_t              res
);
	import das_pkg::*;

	localparam logic signed [ANGW-1:0] TOL_E = ANGW'(YAW_TOL);
	localparam logic signed [ANGW-1:0] LIM_E = ANGW'(YAW_LIMIT);

	logic signed [ANGW-1:0] y_e, band_e, lo_tol, hi_tol, lo_band, hi_band;
	logic signed [CMDW-1:0] slow_s, fast_s;

	assign y_e     = ANGW'(yaw);
	assign band_e  = $signed({{(ANGW-BANDW){1'b0}}, tcfg.band});
	assign lo_tol  = target - TOL_E;
	assign hi_tol  = target + TOL_E;
	assign lo_band = target - band_e;
	assign hi_band = target + band_e;
	assign slow_s  = $signed({1'b0, tcfg.slow_rate});
	assign fast_s  = $signed({1'b0, tcfg.fast_rate});

	// first matching band wins
	always_comb begin
		res.done    = 1'b0;
		res.angular = -fast_s;
		if (y_e >= lo_tol && y_e <= hi_tol) begin
			res.done    = 1'b1;
			res.angular = '0;
		end else if (y_e >= hi_tol && y_e < hi_band) begin
			res.angular = slow_s;
		end else if (y_e >= hi_band && y_e < LIM_E) begin
			res.angular = fast_s;
		end else if (y_e >= lo_band && y_e < lo_tol) begin
			res.angular = -slow_s;
		end
	end
endmodule

// File: design/das_travel.sv
module das_travel (
	input  logic signed [das_pkg::ODW-1:0] odom_x,
	input  logic signed [das_pkg::ODW-1:0] odom_y,
	input  logic signed [das_pkg::ODW-1:0] ref_x,
	input  logic signed [das_pkg::ODW-1:0] ref_y,
	input  logic [das_pkg::SQXW-1:0]       start_sq,
	output logic                           reached
);
	import das_pkg::*;

	localparam int DW  = ODW + 1;
	localparam int SQW = 2 * DW;
	localparam int SCW = SQW + SEG_SQ_W;
	localparam logic [SEG_SQ_W-1:0] SEG_SQ_V = SEG_SQ_W'(SEG_SQ);

	logic signed [DW-1:0]  dx, dy;
	logic signed [SQW-1:0] sq_x, sq_y;
	logic [SQW-1:0]        d2;
	logic [SCW-1:0]        scaled;

	assign dx     = DW'(odom_x) - DW'(ref_x);
	assign dy     = DW'(odom_y) - DW'(ref_y);
	assign sq_x   = SQW'(dx) * SQW'(dx);
	assign sq_y   = SQW'(dy) * SQW'(dy);
	assign d2     = {1'b0, sq_x[SQW-2:0]} + {1'b0, sq_y[SQW-2:0]};
	assign scaled = SCW'(d2) * SCW'(SEG_SQ_V);
	assign reached = scaled >= SCW'(start_sq);
endmodule

// File: design/dock_approach_sequencer_core.sv
// a pose word is first captured in the input register; its command word is then registered in the command register
// throughput: one pose word per cycle, set by the single compute stage between
// the input register and the command register; the stage stalls only on cmd.ready
// reset (arst_n low): phase turn1, held commands, start point and seen flags cleared,
// config registers return to their defaults; cfg writes are taken every cycle
module dock_approach_sequencer_core (
	input  logic         clk,
	input  logic         arst_n,
	das_pose_if.sink     pose,
	das_cmd_if.source    cmd,
	das_cfg_if.sink      cfg
);
	import das_pkg::*;

	// config registers
	logic [SPDW-1:0]  slow_lin_q, fast_lin_q, slow_turn_q, fast_turn_q;
	logic [DISTW-1:0] stop_dist_q, ctr_tol_q, slow_zone_q;
	logic [BANDW-1:0] turn_band_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slow_lin_q  <= RST_SLOW_LIN;
			fast_lin_q  <= RST_FAST_LIN;
			slow_turn_q <= RST_SLOW_TURN;
			fast_turn_q <= RST_FAST_TURN;
			stop_dist_q <= RST_STOP_DIST;
			ctr_tol_q   <= RST_CTR_TOL;
			slow_zone_q <= RST_SLOW_ZONE;
			turn_band_q <= RST_TURN_BAND;
		end else if (cfg.valid) begin
			case (cfg_idx_t'(cfg.index))
				CFG_SLOW_LIN:  slow_lin_q  <= cfg.data[SPDW-1:0];
				CFG_FAST_LIN:  fast_lin_q  <= cfg.data[SPDW-1:0];
				CFG_SLOW_TURN: slow_turn_q <= cfg.data[SPDW-1:0];
				CFG_FAST_TURN: fast_turn_q <= cfg.data[SPDW-1:0];
				CFG_STOP_DIST: stop_dist_q <= cfg.data[DISTW-1:0];
				CFG_CTR_TOL:   ctr_tol_q   <= cfg.data[DISTW-1:0];
				CFG_SLOW_ZONE: slow_zone_q <= cfg.data[DISTW-1:0];
				CFG_TURN_BAND: turn_band_q <= cfg.data[BANDW-1:0];
				default: ;
			endcase
		end
	end

	// input stage
	logic                   valid_s1;
	logic signed [XW-1:0]   dock_x_s1, dock_y_s1;
	logic signed [YAWW-1:0] dock_heading_s1;
	logic signed [ODW-1:0]  odom_x_s1, odom_y_s1;
	logic                   out_valid_q;
	logic                   advance;

	assign advance    = valid_s1 && (!out_valid_q || cmd.ready);
	assign pose.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pose.ready) begin
			valid_s1 <= pose.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pose.valid && pose.ready) begin
			dock_x_s1       <= pose.dock_x;
			dock_y_s1       <= pose.dock_y;
			dock_heading_s1 <= pose.dock_heading;
			odom_x_s1       <= pose.odom_x;
			odom_y_s1       <= pose.odom_y;
		end
	end

	// sequencer state
	phase_t                 phase_q, phase_n;
	logic signed [ODW-1:0]  ref_x_q, ref_y_q, ref_x_n, ref_y_n;
	logic [SQXW-1:0]        start_sq_q, start_sq_n;
	logic                   first_seen_q, second_seen_q, first_seen_n, second_seen_n;
	logic signed [CMDW-1:0] held_lin_q, held_ang_q, held_lin_n, held_ang_n;

	// compute stage
	logic [XW:0]            ax, ay;
	logic [XW:0]            ctol_e, dsd_e, ctol_zone, dsd_zone;
	logic signed [2*XW-1:0] x_sq;
	logic signed [CMDW-1:0] slow_lin_s, fast_lin_s, drive_v;
	logic signed [ANGW-1:0] turn_target;
	logic                   reached, in_ctr, near_dock, retune;
	turn_cfg_t              tcfg;
	turn_res_t              tr;

	assign ax = dock_x_s1[XW-1] ? ({1'b0, ~dock_x_s1} + (XW+1)'(1)) : {1'b0, dock_x_s1};
	assign ay = dock_y_s1[XW-1] ? ({1'b0, ~dock_y_s1} + (XW+1)'(1)) : {1'b0, dock_y_s1};
	assign ctol_e    = (XW+1)'(ctr_tol_q);
	assign dsd_e     = (XW+1)'(stop_dist_q);
	assign ctol_zone = ctol_e + (XW+1)'(slow_zone_q);
	assign dsd_zone  = dsd_e + (XW+1)'(slow_zone_q);
	assign x_sq      = (2*XW)'(dock_x_s1) * (2*XW)'(dock_x_s1);
	assign slow_lin_s = $signed({1'b0, slow_lin_q});
	assign fast_lin_s = $signed({1'b0, fast_lin_q});
	assign drive_v   = (ax > ctol_e && ax < ctol_zone) ? slow_lin_s : fast_lin_s;
	assign in_ctr    = ax <= ctol_e;
	assign near_dock = ax < dsd_e;
	assign retune    = (ay > (XW+1)'(RETUNE_LATERAL)) && (ax <= (XW+1)'(RETUNE_RANGE));
	assign turn_target = (phase_q == PH_TURN2) ? ANGW'(YAW_TARGET2) : '0;

	assign tcfg.slow_rate = slow_turn_q;
	assign tcfg.fast_rate = fast_turn_q;
	assign tcfg.band      = turn_band_q;

	das_turn u_turn (
		.yaw    (dock_heading_s1),
		.target (turn_target),
		.tcfg   (tcfg),
		.res    (tr)
	);

	das_travel u_travel (
		.odom_x   (odom_x_s1),
		.odom_y   (odom_y_s1),
		.ref_x    (ref_x_q),
		.ref_y    (ref_y_q),
		.start_sq (start_sq_q),
		.reached  (reached)
	);

	always_comb begin
		phase_n       = phase_q;
		ref_x_n       = ref_x_q;
		ref_y_n       = ref_y_q;
		start_sq_n    = start_sq_q;
		first_seen_n  = first_seen_q;
		second_seen_n = second_seen_q;
		held_lin_n    = held_lin_q;
		held_ang_n    = held_ang_q;
		case (phase_q)
			PH_TURN1: begin
				held_lin_n = '0;
				held_ang_n = tr.angular;
				if (tr.done) begin
					phase_n = PH_DRIVE;
					if (!first_seen_q) begin
						start_sq_n = x_sq[SQXW-1:0];
						ref_x_n    = odom_x_s1;
						ref_y_n    = odom_y_s1;
					end
				end
			end
			PH_DRIVE: begin
				if (in_ctr || reached) begin
					held_lin_n   = '0;
					first_seen_n = 1'b1;
					if (in_ctr) begin
						phase_n = PH_TURN2;
					end else begin
						ref_x_n = odom_x_s1;
						ref_y_n = odom_y_s1;
						phase_n = PH_TURN1;
					end
				end else begin
					held_lin_n = dock_x_s1[XW-1] ? -drive_v : drive_v;
				end
			end
			PH_TURN2: begin
				held_ang_n = tr.angular;
				if (tr.done) begin
					phase_n = PH_APPROACH;
					if (!second_seen_q) begin
						start_sq_n = x_sq[SQXW-1:0];
						ref_x_n    = odom_x_s1;
						ref_y_n    = odom_y_s1;
					end
				end
			end
			PH_APPROACH: begin
				if (near_dock || reached || retune) begin
					held_lin_n    = '0;
					second_seen_n = 1'b1;
					if (near_dock) begin
						phase_n = PH_STOP;
					end else begin
						ref_x_n = odom_x_s1;
						ref_y_n = odom_y_s1;
						phase_n = retune ? PH_TURN1 : PH_TURN2;
					end
				end else if (ax <= dsd_zone) begin
					held_lin_n = -slow_lin_s;
				end else begin
					held_lin_n = -fast_lin_s;
				end
			end
			PH_STOP: begin
				held_lin_n = '0;
				held_ang_n = '0;
				phase_n    = PH_DONE;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_TURN1;
			ref_x_q       <= '0;
			ref_y_q       <= '0;
			start_sq_q    <= '0;
			first_seen_q  <= 1'b0;
			second_seen_q <= 1'b0;
			held_lin_q    <= '0;
			held_ang_q    <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (advance) begin
				phase_q       <= phase_n;
				ref_x_q       <= ref_x_n;
				ref_y_q       <= ref_y_n;
				start_sq_q    <= start_sq_n;
				first_seen_q  <= first_seen_n;
				second_seen_q <= second_seen_n;
				held_lin_q    <= held_lin_n;
				held_ang_q    <= held_ang_n;
				out_valid_q   <= 1'b1;
			end else if (cmd.ready) begin
				out_valid_q   <= 1'b0;
			end
		end
	end

	// result word is the held state itself
	assign cmd.valid           = out_valid_q;
	assign cmd.linear_command  = held_lin_q;
	assign cmd.angular_command = held_ang_q;
	assign cmd.phase           = phase_code(phase_q);
	assign cmd.finished        = (phase_q == PH_DONE);

	a_phase_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(phase_q))
		else $error("phase register lost its one-hot code");

	a_stop_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		advance && phase_q == PH_STOP |=> phase_q == PH_DONE && held_lin_q == '0
		&& held_ang_q == '0)
		else $error("stop phase did not finish with zero commands");

	a_done_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DONE |=> phase_q == PH_DONE)
		else $error("left the done phase");

	a_turn1_no_drive: assert property (@(posedge clk) disable iff (!arst_n)
		advance && phase_q == PH_TURN1 |=> held_lin_q == '0)
		else $error("linear command nonzero after first turn step");

	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(phase_q) && $stable(held_lin_q) && $stable(held_ang_q))
		else $error("state changed without a word moving through");

	a_no_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ready |-> pose.ready)
		else $error("input stalled while the output side drains");
endmodule

// File: bench/dock_approach_sequencer_core_test.sv
`timescale 1ns / 100ps

module dock_approach_sequencer_core_test;
	import das_pkg::*;

	localparam int X_MIN       = -32768;
	localparam int X_MAX       = 32767;
	localparam int YAW_MAX     = 12868;
	localparam int ODOM_MIN    = -524288;
	localparam int ODOM_MAX    = 524287;
	localparam int SPEED_MAX   = 4095;
	localparam int DIST_MAX    = 32767;
	localparam int BAND_MAX    = 12868;
	localparam int STALL_LIMIT = 4000;
	localparam int PRINT_LIMIT = 40;

	typedef struct {
		logic signed [XW-1:0]   dock_x;
		logic signed [XW-1:0]   dock_y;
		logic signed [YAWW-1:0] dock_heading;
		logic signed [ODW-1:0]  odom_x;
		logic signed [ODW-1:0]  odom_y;
	} pose_word_t;

	typedef struct {
		logic signed [CMDW-1:0] lin;
		logic signed [CMDW-1:0] ang;
		logic [PHW-1:0]         phase;
		logic                   finished;
	} cmd_word_t;

	typedef struct {
		int slow_lin;
		int fast_lin;
		int slow_turn;
		int fast_turn;
		int stop_dist;
		int ctr_tol;
		int slow_zone;
		int turn_band;
	} reg_set_t;

	logic clk = 1'b0;
	logic arst_n;

	das_pose_if pose_ch();
	das_cmd_if  cmd_ch();
	das_cfg_if  cfg_ch();

	dock_approach_sequencer_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pose   (pose_ch),
		.cmd    (cmd_ch),
		.cfg    (cfg_ch)
	);

	always #10 clk = ~clk;

	// sequencer state as the block should hold it
	reg_set_t       live_cfg;
	logic [PHW-1:0] pr_phase;
	int             pr_start_x, pr_ref_x, pr_ref_y;
	bit             pr_seen1, pr_seen2;
	int             pr_lin, pr_ang;

	cmd_word_t pending_cmds[$];
	cmd_word_t head_cmd;
	int        mismatches;
	int        stall_cycles;
	bit        steady;

	function automatic int pick(int lo, int hi);
		return lo + int'($urandom_range(hi - lo));
	endfunction

	function automatic int clamp(int v, int lo, int hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic int magnitude(int v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic int signed_x(int ax);
		return clamp(($urandom_range(1) != 0) ? -ax : ax, X_MIN, X_MAX);
	endfunction

	function automatic pose_word_t pose_at(int x, int y, int yaw, int ox, int oy);
		pose_word_t w;
		w.dock_x       = XW'(x);
		w.dock_y       = XW'(y);
		w.dock_heading = YAWW'(yaw);
		w.odom_x       = ODW'(ox);
		w.odom_y       = ODW'(oy);
		return w;
	endfunction

	function automatic reg_set_t default_regs();
		reg_set_t r;
		r.slow_lin  = RST_SLOW_LIN;
		r.fast_lin  = RST_FAST_LIN;
		r.slow_turn = RST_SLOW_TURN;
		r.fast_turn = RST_FAST_TURN;
		r.stop_dist = RST_STOP_DIST;
		r.ctr_tol   = RST_CTR_TOL;
		r.slow_zone = RST_SLOW_ZONE;
		r.turn_band = RST_TURN_BAND;
		return r;
	endfunction

	function automatic bit segment_covered(int ox, int oy);
		longint dx, dy, d2, lim2;
		dx   = longint'(ox) - pr_ref_x;
		dy   = longint'(oy) - pr_ref_y;
		d2   = dx * dx + dy * dy;
		lim2 = longint'(pr_start_x) * pr_start_x;
		return d2 * (SEGMENT_SPLIT * SEGMENT_SPLIT) >= lim2;
	endfunction

	function automatic bit steer_toward(int yaw, int tgt);
		if (yaw >= tgt - YAW_TOL && yaw <= tgt + YAW_TOL) begin
			pr_ang = 0;
			return 1'b1;
		end
		if (yaw >= tgt + YAW_TOL && yaw < tgt + live_cfg.turn_band)
			pr_ang = live_cfg.slow_turn;
		else if (yaw >= tgt + live_cfg.turn_band && yaw < YAW_LIMIT)
			pr_ang = live_cfg.fast_turn;
		else if (yaw >= tgt - live_cfg.turn_band && yaw < tgt - YAW_TOL)
			pr_ang = -live_cfg.slow_turn;
		else
			pr_ang = -live_cfg.fast_turn;
		return 1'b0;
	endfunction

	function automatic void advance_sequencer(pose_word_t w);
		int x, y, yaw, ox, oy, ax, ay, v;
		bit retune;
		cmd_word_t e;
		x   = int'(w.dock_x);
		y   = int'(w.dock_y);
		yaw = int'(w.dock_heading);
		ox  = int'(w.odom_x);
		oy  = int'(w.odom_y);
		ax  = magnitude(x);
		ay  = magnitude(y);
		case (pr_phase)
			PCODE_TURN1: begin
				pr_lin = 0;
				if (steer_toward(yaw, 0)) begin
					pr_phase = PCODE_DRIVE;
					if (!pr_seen1) begin
						pr_start_x = x;
						pr_ref_x   = ox;
						pr_ref_y   = oy;
					end
				end
			end
			PCODE_DRIVE: begin
				if (ax <= live_cfg.ctr_tol || segment_covered(ox, oy)) begin
					pr_lin   = 0;
					pr_seen1 = 1'b1;
					if (ax <= live_cfg.ctr_tol) begin
						pr_phase = PCODE_TURN2;
					end else begin
						pr_ref_x = ox;
						pr_ref_y = oy;
						pr_phase = PCODE_TURN1;
					end
				end else begin
					v = (ax > live_cfg.ctr_tol && ax < live_cfg.ctr_tol + live_cfg.slow_zone) ?
						live_cfg.slow_lin : live_cfg.fast_lin;
					pr_lin = (x < 0) ? -v : v;
				end
			end
			PCODE_TURN2: begin
				if (steer_toward(yaw, YAW_TARGET2)) begin
					pr_phase = PCODE_APPROACH;
					if (!pr_seen2) begin
						pr_start_x = x;
						pr_ref_x   = ox;
						pr_ref_y   = oy;
					end
				end
			end
			PCODE_APPROACH: begin
				retune = (ay > RETUNE_LATERAL) && (ax <= RETUNE_RANGE);
				if (ax < live_cfg.stop_dist || segment_covered(ox, oy) || retune) begin
					pr_lin   = 0;
					pr_seen2 = 1'b1;
					if (ax < live_cfg.stop_dist) begin
						pr_phase = PCODE_STOP;
					end else begin
						pr_ref_x = ox;
						pr_ref_y = oy;
						pr_phase = retune ? PCODE_TURN1 : PCODE_TURN2;
					end
				end else if (ax <= live_cfg.stop_dist + live_cfg.slow_zone) begin
					pr_lin = -live_cfg.slow_lin;
				end else begin
					pr_lin = -live_cfg.fast_lin;
				end
			end
			PCODE_STOP: begin
				pr_lin   = 0;
				pr_ang   = 0;
				pr_phase = PCODE_DONE;
			end
			default: ;
		endcase
		e.lin      = CMDW'(pr_lin);
		e.ang      = CMDW'(pr_ang);
		e.phase    = pr_phase;
		e.finished = (pr_phase == PCODE_DONE);
		pending_cmds.push_back(e);
	endfunction

	// pose word shaped by the current phase so that most words move the sequence on
	function automatic pose_word_t random_pose(bit may_stop);
		pose_word_t w;
		int roll, tgt, span, ax, yaw;
		w = pose_at(pick(X_MIN, X_MAX), pick(X_MIN, X_MAX), pick(-YAW_MAX, YAW_MAX),
			pick(ODOM_MIN, ODOM_MAX), pick(ODOM_MIN, ODOM_MAX));
		roll = $urandom_range(99);
		span = magnitude(pr_start_x) / SEGMENT_SPLIT + 8;
		if (roll < 80) begin
			w.odom_x = ODW'(clamp(pr_ref_x + pick(-span, span), ODOM_MIN, ODOM_MAX));
			w.odom_y = ODW'(clamp(pr_ref_y + pick(-span, span), ODOM_MIN, ODOM_MAX));
			case (pr_phase)
				PCODE_TURN1, PCODE_TURN2: begin
					tgt = (pr_phase == PCODE_TURN1) ? 0 : YAW_TARGET2;
					if (roll < 30) begin
						yaw = tgt + pick(-YAW_TOL, YAW_TOL);
					end else if (roll < 55) begin
						case ($urandom_range(4))
							0: yaw = tgt + YAW_TOL;
							1: yaw = tgt - YAW_TOL;
							2: yaw = tgt + live_cfg.turn_band;
							3: yaw = tgt - live_cfg.turn_band;
							default: yaw = YAW_LIMIT;
						endcase
						yaw = yaw + pick(-1, 1);
					end else begin
						yaw = tgt + pick(-2 * live_cfg.turn_band - 64, 2 * live_cfg.turn_band + 64);
					end
					w.dock_heading = YAWW'(clamp(yaw, -YAW_MAX, YAW_MAX));
				end
				PCODE_DRIVE: begin
					if (roll < 30)
						w.dock_x = XW'(signed_x(pick(0, clamp(live_cfg.ctr_tol, 0, X_MAX))));
					else if (roll < 55)
						w.dock_x = XW'(signed_x(live_cfg.ctr_tol + pick(0, live_cfg.slow_zone + 1)));
				end
				PCODE_APPROACH: begin
					if (roll < 30)
						w.dock_y = XW'(pick(-RETUNE_LATERAL, RETUNE_LATERAL));
					if (roll < 50) begin
						ax = pick(live_cfg.stop_dist,
							clamp(live_cfg.stop_dist + live_cfg.slow_zone + 1, 0, -X_MIN));
						w.dock_x = XW'(signed_x(ax));
					end else if (roll < 65) begin
						w.dock_x = XW'(signed_x(pick(0, RETUNE_RANGE + 1)));
					end
				end
				default: ;
			endcase
		end
		// keep the approach from reaching the stop band unless the sequence may finish
		if (!may_stop && pr_phase == PCODE_APPROACH &&
				magnitude(int'(w.dock_x)) < live_cfg.stop_dist)
			w.dock_x = XW'(signed_x(pick(live_cfg.stop_dist, -X_MIN)));
		return w;
	endfunction

	task automatic report_mismatch(string what);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("%0t mismatch: %s", $time, what);
	endtask

	task automatic send_pose(pose_word_t w);
		while (!steady && $urandom_range(99) < 37) begin
			pose_ch.valid <= 1'b0;
			@(posedge clk);
		end
		pose_ch.valid        <= 1'b1;
		pose_ch.dock_x       <= w.dock_x;
		pose_ch.dock_y       <= w.dock_y;
		pose_ch.dock_heading <= w.dock_heading;
		pose_ch.odom_x       <= w.odom_x;
		pose_ch.odom_y       <= w.odom_y;
		do @(posedge clk); while (!pose_ch.ready);
		advance_sequencer(w);
	endtask

	task automatic wait_drained();
		pose_ch.valid <= 1'b0;
		while (pending_cmds.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, int value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= CDW'(value);
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			CFG_SLOW_LIN:  live_cfg.slow_lin  = value & 'hFFF;
			CFG_FAST_LIN:  live_cfg.fast_lin  = value & 'hFFF;
			CFG_SLOW_TURN: live_cfg.slow_turn = value & 'hFFF;
			CFG_FAST_TURN: live_cfg.fast_turn = value & 'hFFF;
			CFG_STOP_DIST: live_cfg.stop_dist = value & 'h7FFF;
			CFG_CTR_TOL:   live_cfg.ctr_tol   = value & 'h7FFF;
			CFG_SLOW_ZONE: live_cfg.slow_zone = value & 'h7FFF;
			CFG_TURN_BAND: live_cfg.turn_band = value & 'h3FFF;
			default: ;
		endcase
	endtask

	task automatic load_settings(reg_set_t r);
		wait_drained();
		write_reg(CFG_SLOW_LIN, r.slow_lin);
		write_reg(CFG_FAST_LIN, r.fast_lin);
		write_reg(CFG_SLOW_TURN, r.slow_turn);
		write_reg(CFG_FAST_TURN, r.fast_turn);
		write_reg(CFG_STOP_DIST, r.stop_dist);
		write_reg(CFG_CTR_TOL, r.ctr_tol);
		write_reg(CFG_SLOW_ZONE, r.slow_zone);
		write_reg(CFG_TURN_BAND, r.turn_band);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic run_random(int count);
		for (int n = 0; n < count; n++)
			send_pose(random_pose(1'b0));
	endtask

	// heading bands of the first turn, start latch, drive speeds and segment end
	task automatic test_turn_and_drive();
		send_pose(pose_at(0, 0, YAW_MAX, 0, 0));
		send_pose(pose_at(0, 0, 2000, 0, 0));
		send_pose(pose_at(0, 0, 500, 0, 0));
		send_pose(pose_at(0, 0, -500, 0, 0));
		send_pose(pose_at(0, 0, -YAW_MAX, 0, 0));
		send_pose(pose_at(4096, 0, YAW_TOL, 1000, -1000));
		send_pose(pose_at(4096, 0, 0, 1000, -1000));
		send_pose(pose_at(-200, 0, 0, 1000, -1000));
		send_pose(pose_at(X_MIN, X_MAX, 0, 1000, -1000));
		send_pose(pose_at(X_MAX, X_MIN, 0, 2024, -1000));
		send_pose(pose_at(20000, 0, -YAW_TOL, 5000, 5000));
		send_pose(pose_at(31, 0, 0, 5000, 5000));
	endtask

	// second turn bands, fall-through to fast negative, approach speeds and retune
	task automatic test_second_turn_and_approach();
		send_pose(pose_at(0, 0, YAW_MAX, 0, 0));
		send_pose(pose_at(0, 0, 7000, 0, 0));
		send_pose(pose_at(0, 0, 9000, 0, 0));
		send_pose(pose_at(0, 0, 5000, 0, 0));
		send_pose(pose_at(0, 0, 0, 0, 0));
		send_pose(pose_at(8000, 0, YAW_TARGET2 + YAW_TOL, 0, 0));
		send_pose(pose_at(8000, 0, 0, 0, 0));
		send_pose(pose_at(-500, 5, 0, 100, 100));
		send_pose(pose_at(400, X_MIN, 0, 200, 200));
		send_pose(pose_at(X_MIN, 0, 0, 300, 300));
		send_pose(pose_at(0, 0, 0, 300, 300));
		send_pose(pose_at(0, 0, YAW_TARGET2, 300, 300));
		send_pose(pose_at(9000, 100, 0, 200, 3200));
	endtask

	task automatic test_config_extremes();
		reg_set_t r;
		r = '{0, 0, 0, 0, 0, 0, 0, 0};
		load_settings(r);
		run_random(80);
		r = '{SPEED_MAX, SPEED_MAX, SPEED_MAX, SPEED_MAX, DIST_MAX, DIST_MAX, DIST_MAX, BAND_MAX};
		load_settings(r);
		run_random(80);
	endtask

	task automatic test_random_settings();
		reg_set_t r;
		for (int k = 0; k < 6; k++) begin
			r.slow_lin  = pick(0, SPEED_MAX);
			r.fast_lin  = pick(0, SPEED_MAX);
			r.slow_turn = pick(0, SPEED_MAX);
			r.fast_turn = pick(0, SPEED_MAX);
			r.stop_dist = ($urandom_range(1) != 0) ? pick(0, 1000) : pick(0, DIST_MAX);
			r.ctr_tol   = ($urandom_range(1) != 0) ? pick(0, 1000) : pick(0, DIST_MAX);
			r.slow_zone = ($urandom_range(1) != 0) ? pick(0, 1000) : pick(0, DIST_MAX);
			r.turn_band = ($urandom_range(1) != 0) ? pick(0, 200) : pick(0, BAND_MAX);
			load_settings(r);
			steady = (k == 3);
			run_random(200);
			steady = 1'b0;
		end
	endtask

	// walk to the end of the sequence, then check that done holds its commands
	task automatic test_docking_finish();
		load_settings(default_regs());
		run_random(40);
		while (pr_phase != PCODE_DONE) begin
			case (pr_phase)
				PCODE_TURN1:  send_pose(pose_at(5000, 0, 0, 0, 0));
				PCODE_DRIVE:  send_pose(pose_at(0, 0, 0, 0, 0));
				PCODE_TURN2:  send_pose(pose_at(3000, 0, YAW_TARGET2, 0, 0));
				default:      send_pose(pose_at(0, 0, 0, 0, 0));
			endcase
		end
		send_pose(pose_at(X_MIN, X_MAX, YAW_MAX, ODOM_MIN, ODOM_MAX));
		send_pose(pose_at(X_MAX, X_MIN, -YAW_MAX, ODOM_MAX, ODOM_MIN));
		for (int n = 0; n < 10; n++)
			send_pose(random_pose(1'b1));
	endtask

	always @(posedge clk) begin
		cmd_ch.ready <= steady || ($urandom_range(99) >= 37);
		if (arst_n && cmd_ch.valid && cmd_ch.ready) begin
			if (pending_cmds.size() == 0) begin
				report_mismatch("command word with none expected");
			end else begin
				head_cmd = pending_cmds.pop_front();
				if (cmd_ch.linear_command !== head_cmd.lin)
					report_mismatch($sformatf("linear_command got %0d want %0d",
						cmd_ch.linear_command, head_cmd.lin));
				if (cmd_ch.angular_command !== head_cmd.ang)
					report_mismatch($sformatf("angular_command got %0d want %0d",
						cmd_ch.angular_command, head_cmd.ang));
				if (cmd_ch.phase !== head_cmd.phase)
					report_mismatch($sformatf("phase got %0d want %0d",
						cmd_ch.phase, head_cmd.phase));
				if (cmd_ch.finished !== head_cmd.finished)
					report_mismatch($sformatf("finished got %0b want %0b",
						cmd_ch.finished, head_cmd.finished));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((pose_ch.valid && pose_ch.ready) || (cmd_ch.valid && cmd_ch.ready) ||
					(cfg_ch.valid && cfg_ch.ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("dock_approach_sequencer_core_test NOT OK");
				$finish;
			end
		end
	end

	initial begin
		arst_n               = 1'b0;
		pose_ch.valid        = 1'b0;
		pose_ch.dock_x       = '0;
		pose_ch.dock_y       = '0;
		pose_ch.dock_heading = '0;
		pose_ch.odom_x       = '0;
		pose_ch.odom_y       = '0;
		cmd_ch.ready         = 1'b0;
		cfg_ch.valid         = 1'b0;
		cfg_ch.index         = '0;
		cfg_ch.data          = '0;
		steady               = 1'b0;
		mismatches           = 0;
		stall_cycles         = 0;
		live_cfg             = default_regs();
		pr_phase             = PCODE_TURN1;
		pr_start_x           = 0;
		pr_ref_x             = 0;
		pr_ref_y             = 0;
		pr_seen1             = 1'b0;
		pr_seen2             = 1'b0;
		pr_lin               = 0;
		pr_ang               = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_turn_and_drive();
		test_second_turn_and_approach();
		test_config_extremes();
		test_random_settings();
		test_docking_finish();

		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending_cmds.size() == 0) begin
			$display("dock_approach_sequencer_core_test OK");
		end else begin
			$display("dock_approach_sequencer_core_test NOT OK");
		end
		$finish;
	end

endmodule
